@@ sv/combined_mrg_rng_with_skip_unit_assert.svh @@
// Assertion macros used by the generator controller.
`ifndef COMBINED_MRG_RNG_WITH_SKIP_UNIT_ASSERT_SVH
`define COMBINED_MRG_RNG_WITH_SKIP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMRS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMRS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/cmrs_pkg.sv @@
`default_nettype none

package cmrs_pkg;

  localparam logic [31:0] M_X       = 32'd4294967087;
  localparam logic [31:0] M_Y       = 32'd4294944443;
  localparam logic [14:0] D_X       = 15'd209;
  localparam logic [14:0] D_Y       = 15'd22853;
  localparam logic [31:0] A_X2      = 32'd1403580;
  localparam logic [31:0] A_X3_NEG  = 32'd4294156359;
  localparam logic [31:0] A_Y1      = 32'd527612;
  localparam logic [31:0] A_Y3_NEG  = 32'd4293573854;
  localparam logic [32:0] NORM      = 33'd4294967088;
  localparam logic [31:0] SEED_X_RST = 32'd12345;
  localparam logic [31:0] SEED_Y_RST = 32'd12346;

  localparam logic [1:0] CFG_SEED_X = 2'd0;
  localparam logic [1:0] CFG_SEED_Y = 2'd1;
  localparam logic [1:0] CFG_ANTI   = 2'd2;

  localparam int RAM_DEPTH = 128;
  localparam int RAM_AW    = 7;

  localparam logic [1:0] MAT_A = 2'd0;
  localparam logic [1:0] MAT_P = 2'd1;
  localparam logic [1:0] MAT_T = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SK_INIT,
    ST_SK_LOOP,
    ST_MAC_RA,
    ST_MAC_RB,
    ST_MAC_LB,
    ST_MAC_GO,
    ST_MAC_WAIT,
    ST_VEC_COMMIT,
    ST_CP_RD,
    ST_CP_WR,
    ST_DRAW_OUT,
    ST_COMP
  } state_t;

  typedef enum logic [1:0] {
    JOB_DRAW,
    JOB_MUL,
    JOB_VEC
  } job_t;

  typedef enum logic [1:0] {
    WS_INIT,
    WS_ACC,
    WS_RDATA
  } wsrc_t;

  typedef enum logic {
    OPA_RAM,
    OPA_COEF
  } opa_src_t;

  typedef enum logic {
    OPB_RAM,
    OPB_VEC
  } opb_src_t;

  typedef struct packed {
    logic              sel;
    logic [RAM_AW-1:0] raddr;
    logic              we;
    logic [RAM_AW-1:0] waddr;
    wsrc_t             wsrc;
    logic              lda;
    opa_src_t          opa_src;
    logic              ldb;
    opb_src_t          opb_src;
    logic [1:0]        vidx;
    logic [1:0]        kidx;
    logic              go;
    logic              acc_clr;
    logic              tv_ld;
    logic [1:0]        tv_idx;
    logic              vec_commit;
    logic              load_skip;
    logic              draw_commit;
    logic              comp_out;
    logic              n_shift;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic slot_busy;
    logic n_zero;
    logic n_lsb;
    logic anti;
  } sts_t;

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [RAM_AW-1:0] ram_addr(input logic s, input logic [1:0] mat,
                                                 input logic [3:0] idx);
    return {s, mat, idx};
  endfunction

  function automatic logic [31:0] coef(input logic s, input logic [1:0] k);
    logic [31:0] v;
    v = '0;
    unique case ({s, k})
      3'b000:  v = A_X2;
      3'b001:  v = A_X3_NEG;
      3'b100:  v = A_Y1;
      3'b101:  v = A_Y3_NEG;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Identity for the accumulated jump, one-step companion matrix for the power.
  function automatic logic [31:0] init_val(input logic [RAM_AW-1:0] addr);
    logic [31:0] v;
    v = '0;
    if (addr[5:4] == MAT_A) begin
      if (addr[3:0] == 4'd0 || addr[3:0] == 4'd4 || addr[3:0] == 4'd8) begin
        v = 32'd1;
      end
    end else begin
      case (addr[3:0])
        4'd0:    v = addr[6] ? A_Y1 : '0;
        4'd1:    v = addr[6] ? '0 : A_X2;
        4'd2:    v = addr[6] ? A_Y3_NEG : A_X3_NEG;
        4'd3:    v = 32'd1;
        4'd7:    v = 32'd1;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  function automatic logic [31:0] reduce_seed(input logic [31:0] s, input logic [31:0] m);
    return (s >= m) ? s - m : s;
  endfunction

endpackage

`default_nettype wire

@@ sv/cmrs_ram.sv @@
`default_nettype none

module cmrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/cmrs_ctrl.sv @@
`default_nettype none

`include "combined_mrg_rng_with_skip_unit_assert.svh"

module cmrs_ctrl import cmrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  output logic      item_stall,
  input  wire logic op,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t     state, state_next;
  job_t       job, job_next;
  logic       sel, sel_next;
  logic       sq, sq_next;
  logic [1:0] i, i_next;
  logic [1:0] j, j_next;
  logic [1:0] k, k_next;
  logic [3:0] idx, idx_next;
  logic       pending, pending_next;
  logic [1:0] kmax;
  logic [1:0] dvidx;

  assign kmax = (job == JOB_DRAW) ? 2'd1 : 2'd2;
  assign dvidx = (k == 2'd0) ? (sel ? 2'd0 : 2'd1) : 2'd2;
  assign item_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      job     <= JOB_DRAW;
      sel     <= 1'b0;
      sq      <= 1'b0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
      idx     <= '0;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      job     <= job_next;
      sel     <= sel_next;
      sq      <= sq_next;
      i       <= i_next;
      j       <= j_next;
      k       <= k_next;
      idx     <= idx_next;
      pending <= pending_next;
    end
  end

  always_comb begin
    state_next   = state;
    job_next     = job;
    sel_next     = sel;
    sq_next      = sq;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    idx_next     = idx;
    pending_next = pending;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (op) begin
            sel_next   = 1'b0;
            sq_next    = 1'b0;
            idx_next   = '0;
            state_next = ST_SK_INIT;
          end else if (sts.anti && pending) begin
            state_next = ST_COMP;
          end else begin
            job_next   = JOB_DRAW;
            sel_next   = 1'b0;
            k_next     = '0;
            state_next = ST_MAC_RA;
          end
        end
      end
      ST_SK_INIT: begin
        if (idx == 4'd8) begin
          idx_next = '0;
          if (!sq) begin
            sq_next = 1'b1;
          end else begin
            sq_next = 1'b0;
            if (!sel) begin
              sel_next = 1'b1;
            end else begin
              sel_next   = 1'b0;
              state_next = ST_SK_LOOP;
            end
          end
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      ST_SK_LOOP: begin
        sel_next   = 1'b0;
        i_next     = '0;
        j_next     = '0;
        k_next     = '0;
        state_next = ST_MAC_RA;
        if (sts.n_zero) begin
          job_next = JOB_VEC;
          sq_next  = 1'b0;
        end else begin
          job_next = JOB_MUL;
          sq_next  = !sts.n_lsb;
        end
      end
      ST_MAC_RA:   state_next = ST_MAC_RB;
      ST_MAC_RB:   state_next = ST_MAC_LB;
      ST_MAC_LB:   state_next = ST_MAC_GO;
      ST_MAC_GO:   state_next = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (!sts.busy) begin
          if (k != kmax) begin
            k_next     = k + 2'd1;
            state_next = ST_MAC_RA;
          end else begin
            k_next = '0;
            unique case (job)
              JOB_DRAW: begin
                if (!sel) begin
                  sel_next   = 1'b1;
                  state_next = ST_MAC_RA;
                end else begin
                  state_next = ST_DRAW_OUT;
                end
              end
              JOB_MUL: begin
                if (j == 2'd2) begin
                  j_next = '0;
                  if (i == 2'd2) begin
                    i_next     = '0;
                    idx_next   = '0;
                    state_next = ST_CP_RD;
                  end else begin
                    i_next     = i + 2'd1;
                    state_next = ST_MAC_RA;
                  end
                end else begin
                  j_next     = j + 2'd1;
                  state_next = ST_MAC_RA;
                end
              end
              JOB_VEC: begin
                if (i == 2'd2) begin
                  i_next     = '0;
                  state_next = ST_VEC_COMMIT;
                end else begin
                  i_next     = i + 2'd1;
                  state_next = ST_MAC_RA;
                end
              end
              default: state_next = ST_IDLE;
            endcase
          end
        end
      end
      ST_VEC_COMMIT: begin
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = ST_MAC_RA;
        end else begin
          sel_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_CP_RD: state_next = ST_CP_WR;
      ST_CP_WR: begin
        if (idx == 4'd8) begin
          idx_next = '0;
          if (!sel) begin
            sel_next   = 1'b1;
            state_next = ST_MAC_RA;
          end else if (!sq) begin
            sq_next    = 1'b1;
            sel_next   = 1'b0;
            state_next = ST_MAC_RA;
          end else begin
            sel_next   = 1'b0;
            state_next = ST_SK_LOOP;
          end
        end else begin
          idx_next   = idx + 4'd1;
          state_next = ST_CP_RD;
        end
      end
      ST_DRAW_OUT: begin
        if (!sts.slot_busy) begin
          pending_next = sts.anti;
          state_next   = ST_IDLE;
        end
      end
      ST_COMP: begin
        if (!sts.slot_busy) begin
          pending_next = 1'b0;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.sel     = sel;
    cmd.kidx    = k;
    cmd.wsrc    = WS_INIT;
    cmd.opa_src = OPA_RAM;
    cmd.opb_src = OPB_RAM;
    unique case (state)
      ST_IDLE: begin
        cmd.load_skip = item_valid && op;
      end
      ST_SK_INIT: begin
        cmd.we    = 1'b1;
        cmd.waddr = ram_addr(sel, sq ? MAT_P : MAT_A, idx);
        cmd.wsrc  = WS_INIT;
      end
      ST_MAC_RA: begin
        cmd.raddr   = ram_addr(sel, (job == JOB_MUL && sq) ? MAT_P : MAT_A, idx3(i, k));
        cmd.acc_clr = (k == 2'd0);
      end
      ST_MAC_RB: begin
        cmd.raddr   = ram_addr(sel, MAT_P, idx3(k, j));
        cmd.lda     = 1'b1;
        cmd.opa_src = (job == JOB_DRAW) ? OPA_COEF : OPA_RAM;
      end
      ST_MAC_LB: begin
        cmd.ldb     = 1'b1;
        cmd.opb_src = (job == JOB_MUL) ? OPB_RAM : OPB_VEC;
        cmd.vidx    = (job == JOB_DRAW) ? dvidx : k;
      end
      ST_MAC_GO: begin
        cmd.go = 1'b1;
      end
      ST_MAC_WAIT: begin
        if (!sts.busy && k == kmax) begin
          case (job)
            JOB_DRAW: begin
              cmd.tv_ld  = !sel;
              cmd.tv_idx = 2'd0;
            end
            JOB_MUL: begin
              cmd.we    = 1'b1;
              cmd.waddr = ram_addr(sel, MAT_T, idx3(i, j));
              cmd.wsrc  = WS_ACC;
            end
            JOB_VEC: begin
              cmd.tv_ld  = 1'b1;
              cmd.tv_idx = i;
            end
            default: cmd.tv_ld = 1'b0;
          endcase
        end
      end
      ST_VEC_COMMIT: begin
        cmd.vec_commit = 1'b1;
      end
      ST_CP_RD: begin
        cmd.raddr = ram_addr(sel, MAT_T, idx);
      end
      ST_CP_WR: begin
        cmd.we      = 1'b1;
        cmd.waddr   = ram_addr(sel, sq ? MAT_P : MAT_A, idx);
        cmd.wsrc    = WS_RDATA;
        cmd.n_shift = (idx == 4'd8) && sel && sq;
      end
      ST_DRAW_OUT: begin
        cmd.draw_commit = !sts.slot_busy;
      end
      ST_COMP: begin
        cmd.comp_out = !sts.slot_busy;
      end
      default: cmd.go = 1'b0;
    endcase
  end

  `CMRS_ASSERT_NOW(a_go_pipe_empty, cmd.go, !sts.busy, "Multiply issued while busy.")
  `CMRS_ASSERT_NOW(a_load_slot_free, cmd.draw_commit || cmd.comp_out, !sts.slot_busy,
    "Result loaded into an occupied slot.")
  `CMRS_ASSERT_NOW(a_accept_pipe_empty, !item_stall, !sts.busy,
    "Item accepted while a multiply is in flight.")

endmodule

`default_nettype wire

@@ sv/cmrs_dp.sv @@
`default_nettype none

module cmrs_dp import cmrs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [63:0] skip_count,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      sample
);

  logic [31:0] seed_x, seed_y;
  logic        anti;
  logic [31:0] x_words [3];
  logic [31:0] y_words [3];
  logic [31:0] tv [3];
  logic [31:0] cached;
  logic [62:0] n;
  logic [31:0] opa, opb, acc;
  logic [63:0] prod;
  logic [47:0] fold1;
  logic [32:0] fold2;
  logic [31:0] red;
  logic [3:0]  vpipe;
  logic [31:0] rdata, wdata, vword, m;
  logic [14:0] d;
  logic [32:0] acc_sum;
  logic [32:0] diff;
  logic [31:0] z;

  assign m = cmd.sel ? M_Y : M_X;
  assign d = cmd.sel ? D_Y : D_X;

  cmrs_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.waddr),
    .wdata (wdata),
    .raddr (cmd.raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.wsrc)
      WS_ACC:   wdata = acc;
      WS_RDATA: wdata = rdata;
      default:  wdata = init_val(cmd.waddr);
    endcase
  end

  always_comb begin
    case (cmd.vidx)
      2'd0:    vword = cmd.sel ? y_words[0] : x_words[0];
      2'd1:    vword = cmd.sel ? y_words[1] : x_words[1];
      default: vword = cmd.sel ? y_words[2] : x_words[2];
    endcase
  end

  assign acc_sum = {1'b0, acc} + {1'b0, red};
  assign diff    = {1'b0, tv[0]} - {1'b0, acc};
  assign z       = (tv[0] > acc) ? diff[31:0] : 32'(diff + {1'b0, M_X});

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_x       <= SEED_X_RST;
      seed_y       <= SEED_Y_RST;
      anti         <= 1'b1;
      vpipe        <= '0;
      result_valid <= 1'b0;
      for (int w = 0; w < 3; w++) begin
        x_words[w] <= reduce_seed(SEED_X_RST, M_X);
        y_words[w] <= reduce_seed(SEED_Y_RST, M_Y);
      end
      cached <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SEED_X: seed_x <= cfg_data;
          CFG_SEED_Y: seed_y <= cfg_data;
          CFG_ANTI:   anti   <= cfg_data[0];
          default:    anti   <= anti;
        endcase
      end
      vpipe <= {vpipe[2:0], cmd.go};
      if (cmd.load_skip) begin
        for (int w = 0; w < 3; w++) begin
          x_words[w] <= reduce_seed(seed_x, M_X);
          y_words[w] <= reduce_seed(seed_y, M_Y);
        end
      end else if (cmd.vec_commit) begin
        for (int w = 0; w < 3; w++) begin
          if (cmd.sel) begin
            y_words[w] <= tv[w];
          end else begin
            x_words[w] <= tv[w];
          end
        end
      end else if (cmd.draw_commit) begin
        x_words[2] <= x_words[1];
        x_words[1] <= x_words[0];
        x_words[0] <= tv[0];
        y_words[2] <= y_words[1];
        y_words[1] <= y_words[0];
        y_words[0] <= acc;
        cached     <= z;
      end
      if (cmd.draw_commit || cmd.comp_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_skip) begin
      n <= skip_count[63:1];
    end else if (cmd.n_shift) begin
      n <= n >> 1;
    end
    if (cmd.lda) begin
      opa <= (cmd.opa_src == OPA_COEF) ? coef(cmd.sel, cmd.kidx) : rdata;
    end
    if (cmd.ldb) begin
      opb <= (cmd.opb_src == OPB_VEC) ? vword : rdata;
    end
    if (cmd.tv_ld) begin
      tv[cmd.tv_idx] <= acc;
    end
    prod  <= opa * opb;
    fold1 <= 48'(prod[63:32]) * 48'(d) + 48'(prod[31:0]);
    fold2 <= 33'(fold1[47:32]) * 33'(d) + 33'(fold1[31:0]);
    red   <= (fold2 >= {1'b0, m}) ? 32'(fold2 - {1'b0, m}) : fold2[31:0];
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (vpipe[3]) begin
      acc <= (acc_sum >= {1'b0, m}) ? 32'(acc_sum - {1'b0, m}) : acc_sum[31:0];
    end
    if (cmd.draw_commit) begin
      sample <= z;
    end else if (cmd.comp_out) begin
      sample <= 32'(NORM - {1'b0, cached});
    end
  end

  assign sts.busy      = |vpipe;
  assign sts.slot_busy = result_valid && result_stall;
  assign sts.n_zero    = (n == '0);
  assign sts.n_lsb     = n[0];
  assign sts.anti      = anti;

endmodule

`default_nettype wire

@@ sv/combined_mrg_rng_with_skip_unit.sv @@
// Channel   Handshake                  Payload
// item      item_valid / item_stall    op, skip_count
// result    result_valid / result_stall sample
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A plain draw holds off the next accepted beat while four modular multiplies run one
// after another through the shared five-stage multiply and reduce unit. A complement
// draw loads the complement of the cached sample. A skip runs, for each bit of
// skip_count/2, a squaring and, for a set bit, a multiply, through the same unit and
// the RAM.
// Reset is synchronous; a full result slot with result_stall high holds the next beat.

`default_nettype none

module combined_mrg_rng_with_skip_unit import cmrs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        op,
  input  wire logic [63:0] skip_count,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      sample,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cmrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .sts        (sts),
    .cmd        (cmd)
  );

  cmrs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .skip_count   (skip_count),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample)
  );

endmodule

`default_nettype wire
